@@ design/fcw_pkg.sv @@
package fcw_pkg;

   localparam int TABLE_ENTRIES = 65536;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

   localparam int ACTION_W  = 2;
   localparam int CLUSTER_W = 16;
   localparam int ENTRY_W   = 16;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 17;
   localparam int BYTES_W   = 17;
   localparam int SIZE_W    = 33;

   localparam logic [BYTES_W-1:0] CLUSTER_BYTES_RESET = 17'd2048;
   localparam logic [COUNT_W-1:0] WALK_LIMIT          = COUNT_W'(TABLE_ENTRIES);

   localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MEASURE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_END   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LIMIT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RANGE = 3'd5;

   typedef enum logic [1:0] {
      KIND_NEXT,
      KIND_END,
      KIND_FREE,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 allocated;
      logic [CLUSTER_W-1:0] next_cluster;
      logic [COUNT_W-1:0]   cluster_count;
      logic [SIZE_W-1:0]    byte_size;
   } result_type;

   function automatic kind_type classify(input logic [ENTRY_W-1:0] v);
      kind_type k;
      if (v <= 16'h0001 || (v >= 16'hFFF0 && v <= 16'hFFF6)) begin
         k = KIND_FREE;
      end else if (v == 16'hFFF7) begin
         k = KIND_BAD;
      end else if (v >= 16'hFFF8) begin
         k = KIND_END;
      end else begin
         k = KIND_NEXT;
      end
      return k;
   endfunction

   function automatic logic in_range(input logic [CLUSTER_W-1:0] c);
      return {1'b0, c} < (CLUSTER_W+1)'(TABLE_ENTRIES);
   endfunction

endpackage

@@ design/fcw_if.sv @@
interface fcw_req_if import fcw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [CLUSTER_W-1:0] cluster;
   logic [ENTRY_W-1:0]   entry_value;

   modport source (output valid, action, cluster, entry_value, input ready);
   modport sink   (input valid, action, cluster, entry_value, output ready);
endinterface

interface fcw_rsp_if import fcw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 allocated;
   logic [CLUSTER_W-1:0] next_cluster;
   logic [COUNT_W-1:0]   cluster_count;
   logic [SIZE_W-1:0]    byte_size;

   modport source (output valid, status, allocated, next_cluster, cluster_count, byte_size,
                   input ready);
   modport sink   (input valid, status, allocated, next_cluster, cluster_count, byte_size,
                   output ready);
endinterface

@@ design/fcw_ram.sv @@
module fcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fcw_engine.sv @@
module fcw_engine import fcw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 idle,
   input  logic [ACTION_W-1:0]  action,
   input  logic [CLUSTER_W-1:0] cluster,
   input  logic [ENTRY_W-1:0]   entry_value,
   input  logic [BYTES_W-1:0]   cluster_bytes,
   output logic                 res_valid,
   input  logic                 res_ready,
   output result_type           res
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_HOLD  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [ACTION_W-1:0]  action_ff, action_in;
   logic [CLUSTER_W-1:0] cur_ff, cur_in;
   logic [ENTRY_W-1:0]   val_ff, val_in;
   logic [COUNT_W-1:0]   n_ff, n_in;
   result_type           res_ff, res_in;

   logic                 ram_we;
   logic [ENTRY_W-1:0]   ram_rd;
   logic [COUNT_W-1:0]   n_next;
   logic [33:0]          prod;
   kind_type             kind;

   fcw_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (cur_ff[ADDR_W-1:0]),
      .wr_data (val_ff),
      .rd_data (ram_rd)
   );

   assign kind   = classify(ram_rd);
   assign n_next = n_ff + COUNT_W'(1);
   assign prod   = 34'(res_ff.cluster_count) * 34'(cluster_bytes);

   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      cur_in    = cur_ff;
      val_in    = val_ff;
      n_in      = n_ff;
      res_in    = res_ff;
      ram_we    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               action_in = action;
               cur_in    = cluster;
               val_in    = entry_value;
               n_in      = '0;
               res_in    = '0;
               state_in  = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (action_ff == ACT_NONE) begin
               state_in = S_HOLD;
            end else if (!in_range(cur_ff)) begin
               res_in.status = ST_RANGE;
               state_in      = S_HOLD;
            end else if (action_ff == ACT_WRITE) begin
               ram_we   = 1'b1;
               state_in = S_HOLD;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            n_in     = n_next;
            state_in = S_HOLD;
            if (action_ff == ACT_LOOKUP) begin
               case (kind)
                  KIND_FREE: res_in.status = ST_FREE;
                  KIND_BAD:  res_in.status = ST_BAD;
                  KIND_END: begin
                     res_in.status    = ST_END;
                     res_in.allocated = 1'b1;
                  end
                  default: begin
                     res_in.allocated    = 1'b1;
                     res_in.next_cluster = ram_rd;
                  end
               endcase
            end else begin
               case (kind)
                  KIND_FREE: res_in.status = ST_FREE;
                  KIND_BAD:  res_in.status = ST_BAD;
                  KIND_END: begin
                     res_in.status        = ST_END;
                     res_in.cluster_count = n_next;
                     state_in             = S_MUL;
                  end
                  default: begin
                     if (n_next >= WALK_LIMIT) begin
                        res_in.status = ST_LIMIT;
                     end else begin
                        cur_in   = ram_rd;
                        state_in = S_ISSUE;
                     end
                  end
               endcase
            end
         end
         S_MUL: begin
            res_in.byte_size = prod[SIZE_W-1:0];
            state_in         = S_HOLD;
         end
         S_HOLD: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      action_ff <= action_in;
      cur_ff    <= cur_in;
      val_ff    <= val_in;
      n_ff      <= n_in;
      res_ff    <= res_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_HOLD);
   assign res       = res_ff;

endmodule

@@ design/fat16_chain_walker.sv @@
// FAT16 allocation table with write, lookup and chain-measure actions. The table
// (TABLE_ENTRIES x 16 bits) sits in a single-port RAM with registered read and is
// not cleared: read only entries that were written. One word is taken at a time;
// req ready drops until the result has moved into the output register. A write
// passes an issue state, a lookup an issue and an evaluate state; a chain measure
// passes an issue and an evaluate state per cluster walked (one RAM read and one
// classify step), plus a multiply state when it ends on an end mark (none when it
// stops on a free or bad entry or at the walk limit). A new word is accepted while
// a result waits in the output register.
module fat16_chain_walker import fcw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   fcw_req_if.sink              req_bus,
   fcw_rsp_if.source            rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [BYTES_W-1:0]   csr_wr_data
);

   logic [BYTES_W-1:0] cluster_bytes_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               eng_idle;
   logic               res_valid;
   logic               res_ready;
   result_type         res;

   assign req_bus.ready = eng_idle;
   assign res_ready     = !rsp_valid_ff || rsp_bus.ready;

   fcw_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (req_bus.valid && eng_idle),
      .idle          (eng_idle),
      .action        (req_bus.action),
      .cluster       (req_bus.cluster),
      .entry_value   (req_bus.entry_value),
      .cluster_bytes (cluster_bytes_ff),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_bytes_ff <= CLUSTER_BYTES_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cluster_bytes_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_ff.status;
   assign rsp_bus.allocated     = rsp_ff.allocated;
   assign rsp_bus.next_cluster  = rsp_ff.next_cluster;
   assign rsp_bus.cluster_count = rsp_ff.cluster_count;
   assign rsp_bus.byte_size     = rsp_ff.byte_size;

endmodule

@@ test/fcw_checker.sv @@
`timescale 1ns / 1ps

module fcw_checker import fcw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   fcw_req_if                 req_mon,
   fcw_rsp_if                 rsp_mon,
   input  logic               csr_wr_en,
   input  logic [BYTES_W-1:0] csr_wr_data,
   output int                 fault_count,
   output int                 replies_pending
);

   logic [ENTRY_W-1:0] fat_copy [TABLE_ENTRIES];
   logic [BYTES_W-1:0] bytes_per_cluster = CLUSTER_BYTES_RESET;
   result_type         replies_due [$];
   int                 faults = 0;
   int                 due_count = 0;

   assign fault_count     = faults;
   assign replies_pending = due_count;

   function automatic kind_type entry_kind(input logic [ENTRY_W-1:0] v);
      if (v < 16'h0002) return KIND_FREE;
      if (v >= 16'hFFF0 && v < 16'hFFF7) return KIND_FREE;
      if (v == 16'hFFF7) return KIND_BAD;
      if (v > 16'hFFF7) return KIND_END;
      return KIND_NEXT;
   endfunction

   // applies one word to the table copy and returns the reply it should produce
   function automatic result_type compute_reply(input logic [ACTION_W-1:0]  act,
                                                input logic [CLUSTER_W-1:0] clus,
                                                input logic [ENTRY_W-1:0]   val);
      result_type         r;
      logic [CLUSTER_W:0] cur;
      logic [COUNT_W-1:0] hops;
      logic [ENTRY_W-1:0] v;
      kind_type           k;
      bit                 done;
      r = '0;
      case (act)
         ACT_WRITE: begin
            if ({1'b0, clus} >= (CLUSTER_W+1)'(TABLE_ENTRIES)) r.status = ST_RANGE;
            else fat_copy[clus] = val;
         end
         ACT_LOOKUP: begin
            if ({1'b0, clus} >= (CLUSTER_W+1)'(TABLE_ENTRIES)) begin
               r.status = ST_RANGE;
            end else begin
               v = fat_copy[clus];
               case (entry_kind(v))
                  KIND_FREE: r.status = ST_FREE;
                  KIND_BAD:  r.status = ST_BAD;
                  KIND_END: begin
                     r.status    = ST_END;
                     r.allocated = 1'b1;
                  end
                  default: begin
                     r.allocated    = 1'b1;
                     r.next_cluster = v;
                  end
               endcase
            end
         end
         ACT_MEASURE: begin
            cur  = {1'b0, clus};
            hops = '0;
            done = 1'b0;
            while (!done) begin
               if (cur >= (CLUSTER_W+1)'(TABLE_ENTRIES)) begin
                  r.status = ST_RANGE;
                  done     = 1'b1;
               end else begin
                  v    = fat_copy[cur[CLUSTER_W-1:0]];
                  k    = entry_kind(v);
                  hops = hops + COUNT_W'(1);
                  done = 1'b1;
                  case (k)
                     KIND_FREE: r.status = ST_FREE;
                     KIND_BAD:  r.status = ST_BAD;
                     KIND_END: begin
                        r.status        = ST_END;
                        r.cluster_count = hops;
                        r.byte_size     = SIZE_W'(hops) * SIZE_W'(bytes_per_cluster);
                     end
                     default: begin
                        if (hops >= WALK_LIMIT) r.status = ST_LIMIT;
                        else begin
                           cur  = {1'b0, v};
                           done = 1'b0;
                        end
                     end
                  endcase
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic log_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      faults++;
      $display("%0t fcw_checker: %s got %0h want %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         bytes_per_cluster = CLUSTER_BYTES_RESET;
         replies_due.delete();
      end else begin
         if (csr_wr_en) bytes_per_cluster = csr_wr_data;
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got.status        = rsp_mon.status;
            got.allocated     = rsp_mon.allocated;
            got.next_cluster  = rsp_mon.next_cluster;
            got.cluster_count = rsp_mon.cluster_count;
            got.byte_size     = rsp_mon.byte_size;
            if (replies_due.size() == 0) begin
               log_mismatch("unexpected word, status", 64'(got.status), '0);
            end else begin
               want = replies_due.pop_front();
               if (got.status !== want.status)
                  log_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.allocated !== want.allocated)
                  log_mismatch("allocated", 64'(got.allocated), 64'(want.allocated));
               if (got.next_cluster !== want.next_cluster)
                  log_mismatch("next_cluster", 64'(got.next_cluster),
                               64'(want.next_cluster));
               if (got.cluster_count !== want.cluster_count)
                  log_mismatch("cluster_count", 64'(got.cluster_count),
                               64'(want.cluster_count));
               if (got.byte_size !== want.byte_size)
                  log_mismatch("byte_size", 64'(got.byte_size), 64'(want.byte_size));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            replies_due.push_back(compute_reply(req_mon.action, req_mon.cluster,
                                                req_mon.entry_value));
      end
      due_count <= replies_due.size();
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import fcw_pkg::*;

   localparam int STALL_LIMIT = 400000;
   localparam int SEG_WORDS   = 70;

   localparam logic [ENTRY_W-1:0] FAT_RSV_LO   = 16'hFFF0;
   localparam logic [ENTRY_W-1:0] FAT_RSV_HI   = 16'hFFF6;
   localparam logic [ENTRY_W-1:0] FAT_BAD      = 16'hFFF7;
   localparam logic [ENTRY_W-1:0] FAT_EOC_MIN  = 16'hFFF8;
   localparam logic [ENTRY_W-1:0] FAT_EOC      = 16'hFFFF;
   localparam logic [ENTRY_W-1:0] FAT_NEXT_MAX = 16'hFFEF;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [BYTES_W-1:0] csr_wr_data;
   int                 faults;
   int                 pending;
   int                 quiet_cycles = 0;
   int                 send_gap_pct;
   int                 take_gap_pct;
   bit                 fat_written [TABLE_ENTRIES];
   logic [CLUSTER_W-1:0] written_list [$];
   int                 n_items = 0;
   int                 n_writes = 0;
   int                 n_lookups = 0;
   int                 n_measures = 0;
   int                 n_spare = 0;

   fcw_req_if req_bus ();
   fcw_rsp_if rsp_bus ();

   fat16_chain_walker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   fcw_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fault_count     (faults),
      .replies_pending (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= take_gap_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // returns after the word is taken; the next drive_word or park must follow directly
   task automatic drive_word(input logic [ACTION_W-1:0]  act,
                             input logic [CLUSTER_W-1:0] clus,
                             input logic [ENTRY_W-1:0]   val);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.cluster     <= clus;
      req_bus.entry_value <= val;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      case (act)
         ACT_WRITE:   n_writes++;
         ACT_LOOKUP:  n_lookups++;
         ACT_MEASURE: n_measures++;
         default:     n_spare++;
      endcase
      if (act != ACT_NONE) n_items++;
   endtask

   task automatic park();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      park();
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_cluster_bytes(input logic [BYTES_W-1:0] v);
      drain();
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic put_entry(input logic [CLUSTER_W-1:0] clus, input logic [ENTRY_W-1:0] val);
      drive_word(ACT_WRITE, clus, val);
      if (!fat_written[clus]) begin
         fat_written[clus] = 1'b1;
         written_list.push_back(clus);
      end
   endtask

   function automatic logic [CLUSTER_W-1:0] pick_written();
      return written_list[$urandom_range(0, written_list.size() - 1)];
   endfunction

   function automatic logic [ENTRY_W-1:0] pick_terminal(input int eoc_pct);
      if ($urandom_range(0, 99) < eoc_pct) return ENTRY_W'($urandom_range(FAT_EOC_MIN, FAT_EOC));
      case ($urandom_range(0, 2))
         0:       return ENTRY_W'($urandom_range(0, 1));
         1:       return ENTRY_W'($urandom_range(FAT_RSV_LO, FAT_RSV_HI));
         default: return FAT_BAD;
      endcase
   endfunction

   task automatic run_directed();
      put_entry(16'h0002, FAT_EOC);
      put_entry(16'h0003, 16'h0002);
      put_entry(16'hFFEF, 16'h0003);
      put_entry(16'hFFFF, FAT_NEXT_MAX);
      drive_word(ACT_MEASURE, 16'hFFFF, 16'h0000);
      drive_word(ACT_LOOKUP, 16'hFFFF, 16'hFFFF);
      drive_word(ACT_LOOKUP, 16'h0002, 16'h0000);
      put_entry(16'h0000, 16'h0000);
      drive_word(ACT_LOOKUP, 16'h0000, 16'h0000);
      put_entry(16'h0001, 16'h0001);
      drive_word(ACT_MEASURE, 16'h0001, 16'h0000);
      put_entry(16'h0010, FAT_BAD);
      drive_word(ACT_LOOKUP, 16'h0010, 16'h0000);
      put_entry(16'h0011, 16'h0010);
      drive_word(ACT_MEASURE, 16'h0011, 16'h0000);
      put_entry(16'h0020, FAT_RSV_LO);
      put_entry(16'h0021, FAT_RSV_HI);
      drive_word(ACT_LOOKUP, 16'h0020, 16'h0000);
      drive_word(ACT_LOOKUP, 16'h0021, 16'h0000);
      put_entry(16'h0030, FAT_EOC_MIN);
      drive_word(ACT_LOOKUP, 16'h0030, 16'h0000);
      drive_word(ACT_NONE, 16'hFFFF, 16'hFFFF);
      // two-entry loop, walked until the table size is exhausted, then closed again
      put_entry(16'h0100, FAT_EOC);
      put_entry(16'h0200, 16'h0100);
      put_entry(16'h0100, 16'h0200);
      drive_word(ACT_MEASURE, 16'h0200, 16'h0000);
      put_entry(16'h0100, FAT_EOC);
   endtask

   // links only ever point to a lower cluster, so every walk ends on a written mark
   task automatic build_chain();
      int                   len;
      int                   i;
      logic [CLUSTER_W:0]   cur;
      logic [CLUSTER_W:0]   nxt;
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      cur = (CLUSTER_W+1)'($urandom_range(2, 16'hFF00));
      put_entry(cur[CLUSTER_W-1:0], pick_terminal(80));
      for (i = 1; i < len; i++) begin
         nxt = cur + (CLUSTER_W+1)'($urandom_range(1, 48));
         if (nxt > 17'h0FFFF || cur > {1'b0, FAT_NEXT_MAX}) break;
         put_entry(nxt[CLUSTER_W-1:0], cur[CLUSTER_W-1:0]);
         cur = nxt;
      end
      drive_word(ACT_MEASURE, cur[CLUSTER_W-1:0], ENTRY_W'($urandom));
      if ($urandom_range(0, 3) == 0) drive_word(ACT_LOOKUP, cur[CLUSTER_W-1:0], ENTRY_W'($urandom));
   endtask

   task automatic random_step();
      int                   roll;
      logic [CLUSTER_W-1:0] d;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         build_chain();
      end else if (roll < 58) begin
         d = pick_written();
         if ($urandom_range(0, 1) == 0 && d >= 16'h0002 && d <= FAT_NEXT_MAX) begin
            put_entry(CLUSTER_W'($urandom_range(d + 1, 16'hFFFF)), d);
         end else begin
            put_entry(CLUSTER_W'($urandom), pick_terminal(50));
         end
      end else if (roll < 76) begin
         drive_word(ACT_LOOKUP, pick_written(), ENTRY_W'($urandom));
      end else if (roll < 94) begin
         drive_word(ACT_MEASURE, pick_written(), ENTRY_W'($urandom));
      end else begin
         drive_word(ACT_NONE, CLUSTER_W'($urandom), ENTRY_W'($urandom));
      end
      if ($urandom_range(0, 59) == 0) drain();
   endtask

   initial begin
      logic [BYTES_W-1:0] size_plan [6];
      int                 seg;
      int                 goal;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_WRITE;
      req_bus.cluster     = '0;
      req_bus.entry_value = '0;
      send_gap_pct        = 38;
      take_gap_pct        = 70;
      size_plan[0] = CLUSTER_BYTES_RESET;
      size_plan[1] = 17'd1;
      size_plan[2] = 17'd65536;
      size_plan[3] = 17'h1FFFF;
      size_plan[4] = 17'd0;
      size_plan[5] = BYTES_W'($urandom_range(1, 65536));
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (seg = 0; seg < 6; seg++) begin
         if (seg == 2) begin
            send_gap_pct = 70;
            take_gap_pct = 38;
         end else if (seg == 4) begin
            send_gap_pct = 0;
            take_gap_pct = 0;
         end
         set_cluster_bytes(size_plan[seg]);
         goal = n_items + SEG_WORDS;
         while (n_items < goal) random_step();
      end
      drain();
      repeat (20) @(negedge clock);
      $display("run: %0d table writes, %0d lookups, %0d chain measures, %0d spare-action words",
               n_writes, n_lookups, n_measures, n_spare);
      $display("run: six cluster sizes from 0 to 131071, three pacing mixes, one looped chain");
      if (faults == 0 && pending == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
